// ===== rtl/core/tsct_pkg.sv =====
`default_nettype none

package tsct_pkg;

    // Field widths
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int SUBSEC_W   = 10;
    localparam int SITE_W     = 2;
    localparam int WIN_W      = 30;
    localparam int TIME_W     = 47;
    localparam int INTERVAL_W = 48;
    localparam int OUT_CNT_W  = 32;

    // Default counter width
    localparam int COUNT_BITS_DEF = 32;

    // Window register value after reset
    localparam logic [WIN_W-1:0] WINDOW_RESET = 30'd1000;

    // Nanosecond weights of the timestamp fields
    localparam logic [TIME_W-1:0] NS_PER_HOUR = 47'd3600000000000;
    localparam logic [TIME_W-1:0] NS_PER_MIN  = 47'd60000000000;
    localparam logic [TIME_W-1:0] NS_PER_SEC  = 47'd1000000000;
    localparam logic [TIME_W-1:0] NS_PER_MS   = 47'd1000000;
    localparam logic [TIME_W-1:0] NS_PER_US   = 47'd1000;

    // Site codes
    localparam logic [SITE_W-1:0] SITE_M     = 2'd0;
    localparam logic [SITE_W-1:0] SITE_P     = 2'd1;
    localparam logic [SITE_W-1:0] SITE_C     = 2'd2;
    localparam logic [SITE_W-1:0] SITE_OTHER = 2'd3;

    // Fields that ride along with the timestamp
    typedef struct packed {
        logic [SITE_W-1:0]   site;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
    } t_hit_tag;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic ld_part;
        logic ld_time;
        logic ld_out;
    } t_stage_ctl;

    // One result item
    typedef struct packed {
        logic                         window_full;
        logic                         coincidence;
        logic [OUT_CNT_W-1:0]         coincidence_total;
        logic signed [INTERVAL_W-1:0] interval_ns;
        logic                         second_done;
        logic [OUT_CNT_W-1:0]         second_count;
        logic                         minute_done;
        logic [OUT_CNT_W-1:0]         minute_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/tsct_time.sv =====
`default_nettype none

// Timestamp to integer nanoseconds, two register stages:
// constant-weight partial sums, then the final three-input add.
module tsct_time (
    input  wire logic                            i_clk,
    input  wire tsct_pkg::t_stage_ctl            i_ctl,
    input  wire logic [tsct_pkg::HOUR_W-1:0]     i_hour,
    input  wire logic [tsct_pkg::MINUTE_W-1:0]   i_minute,
    input  wire logic [tsct_pkg::SECOND_W-1:0]   i_second,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]   i_millisecond,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]   i_microsecond,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]   i_nanosecond,
    input  wire logic [tsct_pkg::SITE_W-1:0]     i_site,
    output logic [tsct_pkg::TIME_W-1:0]          o_time,
    output tsct_pkg::t_hit_tag                   o_tag
);

    localparam int TW = tsct_pkg::TIME_W;

    logic [TW-1:0]      n_part_hi, n_part_mid, n_part_lo;
    logic [TW-1:0]      r_part_hi, r_part_mid, r_part_lo;
    tsct_pkg::t_hit_tag n_tag, r_tag_part, r_tag_time;
    logic [TW-1:0]      r_time;

    // Partial sums: hours+minutes, seconds+ms, us+ns (none overflows 47 bits)
    always_comb begin
        n_part_hi  = TW'(i_hour) * tsct_pkg::NS_PER_HOUR
                   + TW'(i_minute) * tsct_pkg::NS_PER_MIN;
        n_part_mid = TW'(i_second) * tsct_pkg::NS_PER_SEC
                   + TW'(i_millisecond) * tsct_pkg::NS_PER_MS;
        n_part_lo  = TW'(i_microsecond) * tsct_pkg::NS_PER_US
                   + TW'(i_nanosecond);
        n_tag.site   = i_site;
        n_tag.second = i_second;
        n_tag.minute = i_minute;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_part) begin
            r_part_hi  <= n_part_hi;
            r_part_mid <= n_part_mid;
            r_part_lo  <= n_part_lo;
            r_tag_part <= n_tag;
        end
    end

    // Final sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_time) begin
            r_time     <= r_part_hi + r_part_mid + r_part_lo;
            r_tag_time <= r_tag_part;
        end
    end

    assign o_time = r_time;
    assign o_tag  = r_tag_time;

endmodule

`default_nettype wire

// ===== rtl/core/tsct_eval.sv =====
`default_nettype none

// Sliding three-hit window, coincidence check, period counters and the
// result register. State advances once per result loaded.
module tsct_eval #(
    parameter int COUNT_BITS = tsct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tsct_pkg::t_stage_ctl            i_ctl,
    input  wire logic [tsct_pkg::WIN_W-1:0]      i_window_ns,
    input  wire logic [tsct_pkg::TIME_W-1:0]     i_time,
    input  wire tsct_pkg::t_hit_tag              i_tag,
    output tsct_pkg::t_result                    o_res
);

    localparam int TW = tsct_pkg::TIME_W;
    localparam int IW = tsct_pkg::INTERVAL_W;
    localparam int OW = tsct_pkg::OUT_CNT_W;
    localparam int WB = (COUNT_BITS > OW) ? COUNT_BITS : OW;
    localparam logic [OW-1:0] OUT_MAX = '1;

    function automatic logic [OW-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        logic [WB-1:0] x;
        x = WB'(v);
        return (x > WB'(OUT_MAX)) ? OUT_MAX : x[OW-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // Window state
    logic [TW-1:0]                r_mid_time;
    logic [TW-1:0]                r_gap_om;     // |middle - older|
    logic [IW-1:0]                r_interval;   // middle - older
    logic [tsct_pkg::SITE_W-1:0]  r_old_site, r_mid_site;
    logic [tsct_pkg::SECOND_W-1:0] r_mid_second;
    logic [tsct_pkg::MINUTE_W-1:0] r_mid_minute;
    logic [1:0]                   r_loaded;
    logic [COUNT_BITS-1:0]        r_coinc_cnt, r_sec_cnt, r_min_cnt;
    tsct_pkg::t_result            r_res;

    logic [IW-1:0]                diff_nm, diff_mn;
    logic [TW-1:0]                gap_nm, win_ext;
    logic                         full, has_m, has_p, has_c, coinc;
    logic                         sec_chg, min_chg;
    logic [COUNT_BITS-1:0]        n_coinc_cnt, n_sec_cnt, n_min_cnt;
    logic [1:0]                   n_loaded;
    tsct_pkg::t_result            n_res;

    // Gap of new hit to middle hit, both signed difference and magnitude
    always_comb begin
        diff_nm = {1'b0, i_time} - {1'b0, r_mid_time};
        diff_mn = {1'b0, r_mid_time} - {1'b0, i_time};
        gap_nm  = diff_nm[IW-1] ? diff_mn[TW-1:0] : diff_nm[TW-1:0];
        win_ext = TW'(i_window_ns);
    end

    // Coincidence and period checks
    always_comb begin
        full  = (r_loaded == 2'd2);
        has_m = (r_old_site == tsct_pkg::SITE_M) || (r_mid_site == tsct_pkg::SITE_M)
             || (i_tag.site == tsct_pkg::SITE_M);
        has_p = (r_old_site == tsct_pkg::SITE_P) || (r_mid_site == tsct_pkg::SITE_P)
             || (i_tag.site == tsct_pkg::SITE_P);
        has_c = (r_old_site == tsct_pkg::SITE_C) || (r_mid_site == tsct_pkg::SITE_C)
             || (i_tag.site == tsct_pkg::SITE_C);
        coinc = full && (r_gap_om < win_ext) && (gap_nm < win_ext)
             && has_m && has_p && has_c;
        sec_chg = full && (i_tag.second != r_mid_second);
        min_chg = full && (i_tag.minute != r_mid_minute);

        n_coinc_cnt = coinc ? sat_inc(r_coinc_cnt) : r_coinc_cnt;
        // The hit that opens a new period counts toward it
        n_sec_cnt   = sat_inc(sec_chg ? '0 : r_sec_cnt);
        n_min_cnt   = sat_inc(min_chg ? '0 : r_min_cnt);
        n_loaded    = full ? r_loaded : r_loaded + 2'd1;

        n_res.window_full       = full;
        n_res.coincidence       = coinc;
        n_res.coincidence_total = clip_out(n_coinc_cnt);
        n_res.interval_ns       = full ? r_interval : '0;
        n_res.second_done       = sec_chg;
        n_res.second_count      = sec_chg ? clip_out(r_sec_cnt) : '0;
        n_res.minute_done       = min_chg;
        n_res.minute_count      = min_chg ? clip_out(r_min_cnt) : '0;
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded     <= '0;
            r_coinc_cnt  <= '0;
            r_sec_cnt    <= '0;
            r_min_cnt    <= '0;
            r_old_site   <= tsct_pkg::SITE_OTHER;
            r_mid_site   <= tsct_pkg::SITE_OTHER;
            r_mid_second <= '0;
            r_mid_minute <= '0;
        end else if (i_ctl.ld_out) begin
            r_loaded     <= n_loaded;
            r_coinc_cnt  <= n_coinc_cnt;
            r_sec_cnt    <= n_sec_cnt;
            r_min_cnt    <= n_min_cnt;
            r_old_site   <= r_mid_site;
            r_mid_site   <= i_tag.site;
            r_mid_second <= i_tag.second;
            r_mid_minute <= i_tag.minute;
        end
    end

    // Time window shift; the new-to-middle gap becomes next hit's older gap
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_mid_time <= i_time;
            r_gap_om   <= gap_nm;
            r_interval <= diff_nm;
            r_res      <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/triple_site_coincidence_trigger_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// hit       in         i_hit_valid / o_hit_stall   i_hour .. i_site
// result    out        o_res_valid / i_res_stall   o_window_full .. o_minute_count
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_window_ns
//
// One hit per cycle sustained while the result channel is not stalled; a hit
// passes the input register, partial sums, time sum, window check and result.
// The only loop is the window state update in the last stage.
// Synchronous active-low reset clears stage valids, counters and window
// fill; the window register returns to 1000 ns. Each stage holds while the
// next one is full and stalled, so bubbles are squeezed out under stall.
module triple_site_coincidence_trigger_core #(
    parameter int COUNT_BITS = tsct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Hit channel
    input  wire logic                              i_hit_valid,
    output logic                                   o_hit_stall,
    input  wire logic [tsct_pkg::HOUR_W-1:0]       i_hour,
    input  wire logic [tsct_pkg::MINUTE_W-1:0]     i_minute,
    input  wire logic [tsct_pkg::SECOND_W-1:0]     i_second,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]     i_millisecond,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]     i_microsecond,
    input  wire logic [tsct_pkg::SUBSEC_W-1:0]     i_nanosecond,
    input  wire logic [tsct_pkg::SITE_W-1:0]       i_site,
    // Result channel
    output logic                                   o_res_valid,
    input  wire logic                              i_res_stall,
    output logic                                   o_window_full,
    output logic                                   o_coincidence,
    output logic [tsct_pkg::OUT_CNT_W-1:0]         o_coincidence_total,
    output logic signed [tsct_pkg::INTERVAL_W-1:0] o_interval_ns,
    output logic                                   o_second_done,
    output logic [tsct_pkg::OUT_CNT_W-1:0]         o_second_count,
    output logic                                   o_minute_done,
    output logic [tsct_pkg::OUT_CNT_W-1:0]         o_minute_count,
    // Configuration write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tsct_pkg::WIN_W-1:0]        i_cfg_window_ns
);

    // Input register
    logic [tsct_pkg::HOUR_W-1:0]   r_hour;
    logic [tsct_pkg::MINUTE_W-1:0] r_minute;
    logic [tsct_pkg::SECOND_W-1:0] r_second;
    logic [tsct_pkg::SUBSEC_W-1:0] r_millisecond, r_microsecond, r_nanosecond;
    logic [tsct_pkg::SITE_W-1:0]   r_site;
    logic [tsct_pkg::WIN_W-1:0]    r_window_ns;

    logic                 r_v_in, r_v_part, r_v_time, r_v_out;
    logic                 adv_in, adv_part, adv_time, adv_out, hit_xfer;
    tsct_pkg::t_stage_ctl ctl;
    logic [tsct_pkg::TIME_W-1:0] hit_time;
    tsct_pkg::t_hit_tag   hit_tag;
    tsct_pkg::t_result    res;

    // Stage advance: a stage moves when empty or when its successor moves
    always_comb begin
        adv_out     = !r_v_out || !i_res_stall;
        adv_time    = !r_v_time || adv_out;
        adv_part    = !r_v_part || adv_time;
        adv_in      = !r_v_in || adv_part;
        hit_xfer    = i_hit_valid && adv_in;
        ctl.ld_part = r_v_in && adv_part;
        ctl.ld_time = r_v_part && adv_time;
        ctl.ld_out  = r_v_time && adv_out;
    end

    assign o_hit_stall = !adv_in;
    assign o_cfg_ready = 1'b1;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_part <= 1'b0;
            r_v_time <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (adv_in)   r_v_in   <= i_hit_valid;
            if (adv_part) r_v_part <= r_v_in;
            if (adv_time) r_v_time <= r_v_part;
            if (adv_out)  r_v_out  <= r_v_time;
        end
    end

    // Hit capture
    always_ff @(posedge i_clk) begin
        if (hit_xfer) begin
            r_hour        <= i_hour;
            r_minute      <= i_minute;
            r_second      <= i_second;
            r_millisecond <= i_millisecond;
            r_microsecond <= i_microsecond;
            r_nanosecond  <= i_nanosecond;
            r_site        <= i_site;
        end
    end

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ns <= tsct_pkg::WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_ns <= i_cfg_window_ns;
        end
    end

    tsct_time u_time (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_hour        (r_hour),
        .i_minute      (r_minute),
        .i_second      (r_second),
        .i_millisecond (r_millisecond),
        .i_microsecond (r_microsecond),
        .i_nanosecond  (r_nanosecond),
        .i_site        (r_site),
        .o_time        (hit_time),
        .o_tag         (hit_tag)
    );

    tsct_eval #(
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_window_ns (r_window_ns),
        .i_time      (hit_time),
        .i_tag       (hit_tag),
        .o_res       (res)
    );

    assign o_res_valid         = r_v_out;
    assign o_window_full       = res.window_full;
    assign o_coincidence       = res.coincidence;
    assign o_coincidence_total = res.coincidence_total;
    assign o_interval_ns       = res.interval_ns;
    assign o_second_done       = res.second_done;
    assign o_second_count      = res.second_count;
    assign o_minute_done       = res.minute_done;
    assign o_minute_count      = res.minute_count;

endmodule

`default_nettype wire

// ===== verif/triple_site_coincidence_trigger_core_tb.sv =====
`default_nettype none

module triple_site_coincidence_trigger_core_tb;

    localparam int              SW         = tsct_pkg::SITE_W;
    localparam int              WW         = tsct_pkg::WIN_W;
    localparam longint unsigned DAY_NS     = 64'd86400000000000;
    localparam longint unsigned TIME_MASK  = (64'd1 << tsct_pkg::TIME_W) - 64'd1;
    localparam int unsigned     STALL_MAX  = 13;
    localparam int unsigned     DEAD_LIMIT = 3000;

    // One hit as it sits on the input pins
    typedef struct packed {
        logic [tsct_pkg::HOUR_W-1:0]   hour;
        logic [tsct_pkg::MINUTE_W-1:0] minute;
        logic [tsct_pkg::SECOND_W-1:0] second;
        logic [tsct_pkg::SUBSEC_W-1:0] millisecond;
        logic [tsct_pkg::SUBSEC_W-1:0] microsecond;
        logic [tsct_pkg::SUBSEC_W-1:0] nanosecond;
        logic [tsct_pkg::SITE_W-1:0]   site;
    } t_hit;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                   i_hit_valid = 1'b0;
    logic                                   o_hit_stall;
    t_hit                                   hit_drv     = '0;
    logic                                   o_res_valid;
    logic                                   i_res_stall = 1'b0;
    logic                                   o_window_full;
    logic                                   o_coincidence;
    logic [tsct_pkg::OUT_CNT_W-1:0]         o_coincidence_total;
    logic signed [tsct_pkg::INTERVAL_W-1:0] o_interval_ns;
    logic                                   o_second_done;
    logic [tsct_pkg::OUT_CNT_W-1:0]         o_second_count;
    logic                                   o_minute_done;
    logic [tsct_pkg::OUT_CNT_W-1:0]         o_minute_count;
    logic                                   i_cfg_valid     = 1'b0;
    logic                                   o_cfg_ready;
    logic [WW-1:0]                          i_cfg_window_ns = '0;

    always #5 i_clk = ~i_clk;

    triple_site_coincidence_trigger_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_hit_valid         (i_hit_valid),
        .o_hit_stall         (o_hit_stall),
        .i_hour              (hit_drv.hour),
        .i_minute            (hit_drv.minute),
        .i_second            (hit_drv.second),
        .i_millisecond       (hit_drv.millisecond),
        .i_microsecond       (hit_drv.microsecond),
        .i_nanosecond        (hit_drv.nanosecond),
        .i_site              (hit_drv.site),
        .o_res_valid         (o_res_valid),
        .i_res_stall         (i_res_stall),
        .o_window_full       (o_window_full),
        .o_coincidence       (o_coincidence),
        .o_coincidence_total (o_coincidence_total),
        .o_interval_ns       (o_interval_ns),
        .o_second_done       (o_second_done),
        .o_second_count      (o_second_count),
        .o_minute_done       (o_minute_done),
        .o_minute_count      (o_minute_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_ns     (i_cfg_window_ns)
    );

    // Hits waiting to be driven, results waiting to arrive
    t_hit              pending_hits[$];
    tsct_pkg::t_result pending_results[$];
    int unsigned       mismatches = 0;

    // Transfer flags, updated at each rising edge
    bit hit_taken = 1'b0;
    bit res_taken = 1'b0;

    // Trigger state mirrored from the block
    logic [WW-1:0]                   window_cfg    = tsct_pkg::WINDOW_RESET;
    longint unsigned                 older_time    = 0;
    longint unsigned                 middle_time   = 0;
    logic [SW-1:0]                   older_site    = tsct_pkg::SITE_OTHER;
    logic [SW-1:0]                   middle_site   = tsct_pkg::SITE_OTHER;
    logic [tsct_pkg::SECOND_W-1:0]   middle_second = '0;
    logic [tsct_pkg::MINUTE_W-1:0]   middle_minute = '0;
    int unsigned                     hits_held     = 0;
    logic [tsct_pkg::OUT_CNT_W-1:0]  coinc_total   = '0;
    logic [tsct_pkg::OUT_CNT_W-1:0]  second_hits   = '0;
    logic [tsct_pkg::OUT_CNT_W-1:0]  minute_hits   = '0;

    function automatic logic [tsct_pkg::OUT_CNT_W-1:0] bump(
        input logic [tsct_pkg::OUT_CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic longint unsigned time_gap(input longint unsigned a,
                                                 input longint unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic int unsigned pick_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    // Work out the result of one hit and advance the window
    task automatic predict_trigger(input t_hit h);
        longint unsigned   t_new;
        tsct_pkg::t_result r;
        logic              has_m, has_p, has_c;
        t_new = 64'(h.hour) * 64'(tsct_pkg::NS_PER_HOUR)
              + 64'(h.minute) * 64'(tsct_pkg::NS_PER_MIN)
              + 64'(h.second) * 64'(tsct_pkg::NS_PER_SEC)
              + 64'(h.millisecond) * 64'(tsct_pkg::NS_PER_MS)
              + 64'(h.microsecond) * 64'(tsct_pkg::NS_PER_US)
              + 64'(h.nanosecond);
        t_new = t_new & TIME_MASK;
        r = '0;
        if (hits_held >= 2) begin
            r.window_full = 1'b1;
            has_m = (older_site == tsct_pkg::SITE_M) || (middle_site == tsct_pkg::SITE_M)
                 || (h.site == tsct_pkg::SITE_M);
            has_p = (older_site == tsct_pkg::SITE_P) || (middle_site == tsct_pkg::SITE_P)
                 || (h.site == tsct_pkg::SITE_P);
            has_c = (older_site == tsct_pkg::SITE_C) || (middle_site == tsct_pkg::SITE_C)
                 || (h.site == tsct_pkg::SITE_C);
            if (time_gap(older_time, middle_time) < 64'(window_cfg) &&
                time_gap(t_new, middle_time) < 64'(window_cfg) &&
                has_m && has_p && has_c) begin
                r.coincidence = 1'b1;
                coinc_total = bump(coinc_total);
            end
            if (h.second != middle_second) begin
                r.second_done  = 1'b1;
                r.second_count = second_hits;
                second_hits    = '0;
            end
            if (h.minute != middle_minute) begin
                r.minute_done  = 1'b1;
                r.minute_count = minute_hits;
                minute_hits    = '0;
            end
            r.interval_ns = tsct_pkg::INTERVAL_W'(middle_time - older_time);
        end else begin
            hits_held++;
        end
        second_hits = bump(second_hits);
        minute_hits = bump(minute_hits);
        r.coincidence_total = coinc_total;
        older_time    = middle_time;
        older_site    = middle_site;
        middle_time   = t_new;
        middle_site   = h.site;
        middle_second = h.second;
        middle_minute = h.minute;
        pending_results.push_back(r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: record transfers, predict on hit transfers, check result transfers
    always @(posedge i_clk) begin : monitor
        tsct_pkg::t_result want;
        hit_taken = i_rst_n && i_hit_valid && !o_hit_stall;
        res_taken = i_rst_n && o_res_valid && !i_res_stall;
        if (hit_taken)
            predict_trigger(hit_drv);
        if (res_taken) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no result expected");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("window_full", want.window_full, o_window_full);
                check_field("coincidence", want.coincidence, o_coincidence);
                check_field("coincidence_total", want.coincidence_total,
                            o_coincidence_total);
                check_field("interval_ns", want.interval_ns, o_interval_ns);
                check_field("second_done", want.second_done, o_second_done);
                check_field("second_count", want.second_count, o_second_count);
                check_field("minute_done", want.minute_done, o_minute_done);
                check_field("minute_count", want.minute_count, o_minute_count);
            end
        end
    end

    // Hit driver: one pending hit at a time, random gap after each
    int unsigned hit_gap  = 0;
    bit          hit_calm = 1'b0;

    always @(negedge i_clk) begin : hit_driver
        logic v;
        t_hit nxt;
        v = i_hit_valid;
        if (v && hit_taken)
            v = 1'b0;
        if (!v) begin
            if (hit_gap != 0) begin
                hit_gap--;
            end else if (pending_hits.size() != 0) begin
                nxt = pending_hits.pop_front();
                hit_drv <= nxt;
                v = 1'b1;
                hit_gap = pick_wait(hit_calm);
                if ($urandom_range(0, 39) == 0)
                    hit_calm = !hit_calm;
            end
        end
        i_hit_valid <= v;
    end

    // Result back-pressure: random stall run after each result
    int unsigned res_hold = 0;
    bit          res_calm = 1'b0;

    always @(negedge i_clk) begin : result_stall
        if (res_taken) begin
            res_hold = pick_wait(res_calm);
            if ($urandom_range(0, 39) == 0)
                res_calm = !res_calm;
        end
        if (res_hold != 0) begin
            i_res_stall <= 1'b1;
            res_hold--;
        end else begin
            i_res_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer
    int unsigned dead_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((i_hit_valid && !o_hit_stall) || (o_res_valid && !i_res_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            dead_cycles = 0;
        end else begin
            dead_cycles++;
            if (dead_cycles >= DEAD_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Timestamp fields of an absolute time in ns
    function automatic t_hit hit_at(input longint unsigned t, input logic [SW-1:0] s);
        t_hit            h;
        longint unsigned q;
        q             = t / tsct_pkg::NS_PER_HOUR;
        h.hour        = q[tsct_pkg::HOUR_W-1:0];
        t             = t % tsct_pkg::NS_PER_HOUR;
        q             = t / tsct_pkg::NS_PER_MIN;
        h.minute      = q[tsct_pkg::MINUTE_W-1:0];
        t             = t % tsct_pkg::NS_PER_MIN;
        q             = t / tsct_pkg::NS_PER_SEC;
        h.second      = q[tsct_pkg::SECOND_W-1:0];
        t             = t % tsct_pkg::NS_PER_SEC;
        q             = t / tsct_pkg::NS_PER_MS;
        h.millisecond = q[tsct_pkg::SUBSEC_W-1:0];
        t             = t % tsct_pkg::NS_PER_MS;
        q             = t / tsct_pkg::NS_PER_US;
        h.microsecond = q[tsct_pkg::SUBSEC_W-1:0];
        q             = t % tsct_pkg::NS_PER_US;
        h.nanosecond  = q[tsct_pkg::SUBSEC_W-1:0];
        h.site        = s;
        return h;
    endfunction

    // Any bit pattern, out-of-range fields included
    function automatic t_hit noise_hit();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_hit)-1:0];
    endfunction

    task automatic wait_drained();
        while (pending_hits.size() != 0 || i_hit_valid || pending_results.size() != 0)
            @(posedge i_clk);
        // pipeline depth plus margin
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WW-1:0] w);
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_window_ns <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        window_cfg = w;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly clustered hit trains with rotating sites, plus jumps and noise
    task automatic queue_random_hits(input int n);
        longint unsigned t, span, step;
        logic [SW-1:0]   s, s_last, s_prev;
        int unsigned     r;
        t      = {$urandom, $urandom} % DAY_NS;
        span   = (window_cfg == '0) ? 64'd1000 :
                 (window_cfg > 30'd2000000) ? 64'd2000000 : 64'(window_cfg);
        s_last = tsct_pkg::SITE_OTHER;
        s_prev = tsct_pkg::SITE_OTHER;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 95) begin
                if (r < 6) begin
                    step = 64'($urandom_range(0, 32'(2 * span)));
                    t = (t > step) ? t - step : t + step;
                end else if (r < 55) begin
                    t = t + 64'($urandom_range(0, 32'(2 * span)));
                end else if (r < 75) begin
                    // right around the window edge
                    t = t + span - 64'd1 + 64'($urandom_range(0, 2));
                end else if (r < 85) begin
                    t = t + 64'($urandom_range(1, 3)) * 64'(tsct_pkg::NS_PER_SEC)
                          + 64'($urandom_range(0, 32'(span)));
                end else if (r < 90) begin
                    t = t + 64'($urandom_range(1, 2)) * 64'(tsct_pkg::NS_PER_MIN)
                          + 64'($urandom_range(0, 32'(span)));
                end else begin
                    t = {$urandom, $urandom} % DAY_NS;
                end
                if (t >= DAY_NS)
                    t = t % DAY_NS;
                if ($urandom_range(0, 1) && s_last != s_prev &&
                    s_last != tsct_pkg::SITE_OTHER && s_prev != tsct_pkg::SITE_OTHER)
                    s = tsct_pkg::SITE_M + tsct_pkg::SITE_P + tsct_pkg::SITE_C
                      - s_last - s_prev;
                else
                    s = SW'($urandom_range(0, 3));
                pending_hits.push_back(hit_at(t, s));
                s_prev = s_last;
                s_last = s;
            end else begin
                pending_hits.push_back(noise_hit());
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        longint unsigned base;
        t_hit            h;
        logic [WW-1:0]   windows[6];

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed hits at the reset window of 1000 ns
        base = 64'd10 * tsct_pkg::NS_PER_HOUR + 64'd20 * tsct_pkg::NS_PER_MIN
             + 64'd30 * tsct_pkg::NS_PER_SEC;
        pending_hits.push_back(hit_at(0, tsct_pkg::SITE_M));
        h = '1;
        pending_hits.push_back(h);
        pending_hits.push_back(hit_at(base, tsct_pkg::SITE_M));
        pending_hits.push_back(hit_at(base + 999, tsct_pkg::SITE_P));
        pending_hits.push_back(hit_at(base + 1998, tsct_pkg::SITE_C)); // both gaps just inside
        pending_hits.push_back(hit_at(base + 2997, tsct_pkg::SITE_M));
        pending_hits.push_back(hit_at(base + 3997, tsct_pkg::SITE_P)); // newest gap on the edge
        pending_hits.push_back(hit_at(base + 4996, tsct_pkg::SITE_C)); // older gap on the edge
        pending_hits.push_back(hit_at(base + 5995, tsct_pkg::SITE_M));
        pending_hits.push_back(hit_at(base + 5995, tsct_pkg::SITE_OTHER));
        pending_hits.push_back(hit_at(base + 5995, tsct_pkg::SITE_P));
        pending_hits.push_back(hit_at(base + 5500, tsct_pkg::SITE_C)); // time runs backward
        pending_hits.push_back(hit_at(base + 5800, tsct_pkg::SITE_M));
        pending_hits.push_back(hit_at(base + tsct_pkg::NS_PER_SEC, tsct_pkg::SITE_M));
        pending_hits.push_back(hit_at(base + tsct_pkg::NS_PER_SEC + tsct_pkg::NS_PER_MIN,
                                      tsct_pkg::SITE_P));
        pending_hits.push_back(hit_at(base + 64'd2 * tsct_pkg::NS_PER_SEC
                                      + 64'd2 * tsct_pkg::NS_PER_MIN, tsct_pkg::SITE_C));
        h = '0;
        h.millisecond = '1;
        pending_hits.push_back(h);
        h = '0;
        h.microsecond = '1;
        h.site = tsct_pkg::SITE_P;
        pending_hits.push_back(h);
        h = '0;
        h.nanosecond = '1;
        h.site = tsct_pkg::SITE_C;
        pending_hits.push_back(h);
        h = '0;
        h.hour = '1;
        h.site = tsct_pkg::SITE_OTHER;
        pending_hits.push_back(h);
        pending_hits.push_back(noise_hit());
        pending_hits.push_back(noise_hit());
        queue_random_hits(200);

        // Window settings, extremes among them
        windows[0] = '0;
        windows[1] = '1;
        windows[2] = 30'd1;
        windows[3] = 30'd1000000000;
        windows[4] = WW'($urandom_range(2, 100000));
        windows[5] = 30'd5000;
        foreach (windows[i]) begin
            wait_drained();
            write_window(windows[i]);
            queue_random_hits(290);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/tsct_pkg.sv
rtl/core/tsct_time.sv
rtl/core/tsct_eval.sv
rtl/core/triple_site_coincidence_trigger_core.sv
verif/triple_site_coincidence_trigger_core_tb.sv
